@@ src/rpa_pkg.sv @@
// Shared types and codes for the reference-counted page allocator.
package rpa_pkg;

   // Operation codes
   localparam logic [1:0] OP_ALLOC  = 2'd0;
   localparam logic [1:0] OP_FREE   = 2'd1;
   localparam logic [1:0] OP_ADDREF = 2'd2;
   localparam logic [1:0] OP_INIT   = 2'd3;

   // Result status codes
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_OOM        = 3'd1;
   localparam logic [2:0] ST_BADADDR    = 3'd2;
   localparam logic [2:0] ST_DOUBLEFREE = 3'd3;
   localparam logic [2:0] ST_SATURATED  = 3'd4;

   // Register index, taken from paddr[2]
   localparam logic CSR_IDX_FIRST_PAGE = 1'b0;
   localparam logic CSR_IDX_PAGE_COUNT = 1'b1;

   // Register widths and reset values
   localparam int unsigned FIRST_PAGE_W = 20;
   localparam int unsigned PAGE_COUNT_W = 16;
   localparam logic [15:0] PAGE_COUNT_RESET = 16'h8000;

   // Controller states
   typedef enum logic [1:0] {
      S_IDLE,
      S_DECODE,
      S_WALK,
      S_COMPLETE
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic accept;
      logic decode;
      logic walk;
      logic complete;
   } ctrl_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic is_init;
      logic walk_last;
   } dp_status_type;

endpackage

@@ src/rpa_csr.sv @@
// Configuration registers and managed window size of the page allocator.
module rpa_csr #(
   parameter int NUM_PAGES  = 32768,
   parameter int PAGE_BYTES = 4096,
   parameter int CNT_W      = $clog2(NUM_PAGES + 1)
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [2:0]                             paddr,
   input  logic [31:0]                            pwdata,
   output logic [31:0]                            prdata,
   output logic                                   pready,
   output logic [rpa_pkg::FIRST_PAGE_W-1:0]       first_page,
   output logic [CNT_W-1:0]                       window
);

   localparam int PS = $clog2(PAGE_BYTES);
   localparam logic [31:0] ADDRESSABLE = 32'(1) << (32 - PS);

   logic [rpa_pkg::FIRST_PAGE_W-1:0] first_page_ff;
   logic [rpa_pkg::PAGE_COUNT_W-1:0] page_count_ff;
   logic [CNT_W-1:0]                 window_ff;
   logic [CNT_W-1:0]                 window_in;
   logic                             wr_en;
   logic [31:0]                      first_c;
   logic [31:0]                      limit_c;
   logic [31:0]                      rem_c;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         first_page_ff <= '0;
         page_count_ff <= rpa_pkg::PAGE_COUNT_RESET;
      end else if (wr_en) begin
         case (paddr[2])
            rpa_pkg::CSR_IDX_FIRST_PAGE: first_page_ff <= pwdata[rpa_pkg::FIRST_PAGE_W-1:0];
            rpa_pkg::CSR_IDX_PAGE_COUNT: page_count_ff <= pwdata[rpa_pkg::PAGE_COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      case (paddr[2])
         rpa_pkg::CSR_IDX_FIRST_PAGE: prdata = 32'(first_page_ff);
         rpa_pkg::CSR_IDX_PAGE_COUNT: prdata = 32'(page_count_ff);
         default:                     prdata = '0;
      endcase
   end

   // Clip the page count to the pool size and to the 32-bit address space
   always_comb begin
      first_c = 32'(first_page_ff);
      limit_c = (32'(page_count_ff) > 32'(NUM_PAGES)) ? 32'(NUM_PAGES) : 32'(page_count_ff);
      rem_c   = ADDRESSABLE - first_c;
      if (first_c >= ADDRESSABLE) begin
         window_in = '0;
      end else if (limit_c > rem_c) begin
         window_in = rem_c[CNT_W-1:0];
      end else begin
         window_in = limit_c[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else begin
         window_ff <= window_in;
      end
   end

   assign first_page = first_page_ff;
   assign window     = window_ff;

endmodule

@@ src/rpa_ctrl.sv @@
// Controller state machine of the page allocator.
module rpa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  rpa_pkg::dp_status_type dp_status,
   output rpa_pkg::ctrl_cmd_type  cmd
);

   rpa_pkg::state_type state_ff;
   rpa_pkg::state_type state_in;
   logic               accept;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rpa_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands; a new transaction may enter while the last one completes
   always_comb begin
      busy     = !(state_ff == rpa_pkg::S_IDLE || state_ff == rpa_pkg::S_COMPLETE);
      accept   = start & ~busy;
      state_in = state_ff;
      cmd      = '0;
      cmd.accept = accept;
      case (state_ff)
         rpa_pkg::S_IDLE: begin
            if (accept) state_in = rpa_pkg::S_DECODE;
         end
         rpa_pkg::S_DECODE: begin
            cmd.decode = 1'b1;
            state_in   = dp_status.is_init ? rpa_pkg::S_WALK : rpa_pkg::S_COMPLETE;
         end
         rpa_pkg::S_WALK: begin
            cmd.walk = 1'b1;
            if (dp_status.walk_last) state_in = rpa_pkg::S_COMPLETE;
         end
         rpa_pkg::S_COMPLETE: begin
            cmd.complete = 1'b1;
            state_in     = accept ? rpa_pkg::S_DECODE : rpa_pkg::S_IDLE;
         end
         default: state_in = rpa_pkg::S_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   a_accept_decodes: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> state_ff == rpa_pkg::S_DECODE)
      else $error("accepted transaction did not enter decode");
   a_complete_once: assert property (@(posedge clock) disable iff (reset)
      cmd.complete |=> (state_ff == rpa_pkg::S_IDLE || state_ff == rpa_pkg::S_DECODE))
      else $error("complete state lasted more than one cycle");
   a_one_phase: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.decode, cmd.walk, cmd.complete}))
      else $error("more than one datapath phase commanded");
`endif

endmodule

@@ src/rpa_dp.sv @@
// Datapath of the page allocator: free stack, reference counts and result logic.
module rpa_dp #(
   parameter int NUM_PAGES     = 32768,
   parameter int PAGE_BYTES    = 4096,
   parameter int REFCOUNT_BITS = 8,
   parameter int CNT_W         = $clog2(NUM_PAGES + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  rpa_pkg::ctrl_cmd_type             cmd,
   output rpa_pkg::dp_status_type            dp_status,
   input  logic [1:0]                        req_opcode,
   input  logic [31:0]                       req_address,
   input  logic [rpa_pkg::FIRST_PAGE_W-1:0]  first_page,
   input  logic [CNT_W-1:0]                  window,
   output logic                              rsp_valid,
   output logic [31:0]                       rsp_page_address,
   output logic [2:0]                        rsp_status,
   output logic [7:0]                        rsp_ref_count,
   output logic                              rsp_returned_to_pool
);

   localparam int IDX_W = $clog2(NUM_PAGES);
   localparam int PS    = $clog2(PAGE_BYTES);
   localparam logic [31:0]              PAGE_MASK = 32'(PAGE_BYTES - 1);
   localparam logic [REFCOUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [REFCOUNT_BITS-1:0] COUNT_ONE = REFCOUNT_BITS'(1);

   // Storage
   logic [IDX_W-1:0]         stack_mem [NUM_PAGES];
   logic [REFCOUNT_BITS-1:0] ref_mem   [NUM_PAGES];

   logic [1:0]               op_ff;
   logic [31:0]              addr_ff;
   logic [IDX_W-1:0]         idx_ff;
   logic                     ok_ff;
   logic                     empty_ff;
   logic [CNT_W-1:0]         fc_ff;
   logic [CNT_W-1:0]         fc_in;
   logic [IDX_W-1:0]         walk_ff;
   logic [IDX_W-1:0]         stack_rd_ff;
   logic [REFCOUNT_BITS-1:0] ref_rd_ff;

   // Lookup
   logic [31:0]              page_c;
   logic [31:0]              rel_c;
   logic                     lk_ok_c;
   logic [IDX_W-1:0]         lk_idx_c;
   logic [IDX_W-1:0]         stack_raddr_c;

   // Completion
   logic                     ref_we_c;
   logic [IDX_W-1:0]         ref_waddr_c;
   logic [REFCOUNT_BITS-1:0] ref_wdata_c;
   logic                     stack_we_c;
   logic [IDX_W-1:0]         stack_waddr_c;
   logic [IDX_W-1:0]         stack_wdata_c;
   logic [REFCOUNT_BITS-1:0] cnt_c;
   logic [REFCOUNT_BITS+7:0] cnt_ext_c;
   logic [31:0]              page_sum_c;
   logic                     push_c;

   // Latch the transaction
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff   <= req_opcode;
         addr_ff <= req_address;
      end
   end

   // Translate the address into a window index
   always_comb begin
      page_c        = addr_ff >> PS;
      rel_c         = page_c - 32'(first_page);
      lk_ok_c       = ((addr_ff & PAGE_MASK) == '0) && (page_c >= 32'(first_page)) &&
                      (rel_c < 32'(window));
      lk_idx_c      = rel_c[IDX_W-1:0];
      stack_raddr_c = IDX_W'(fc_ff - CNT_W'(1));
   end

   // Hold lookup results for the completion cycle
   always_ff @(posedge clock) begin
      if (cmd.decode) begin
         idx_ff   <= lk_idx_c;
         ok_ff    <= lk_ok_c;
         empty_ff <= (fc_ff == '0);
      end
   end

   // Advance the init walk
   always_ff @(posedge clock) begin
      if (reset) begin
         walk_ff <= '0;
      end else if (cmd.decode) begin
         walk_ff <= '0;
      end else if (cmd.walk) begin
         walk_ff <= walk_ff + IDX_W'(1);
      end
   end

   assign dp_status.is_init   = (op_ff == rpa_pkg::OP_INIT);
   assign dp_status.walk_last = (walk_ff == IDX_W'(NUM_PAGES - 1));

   // Work out the result and the memory updates
   always_comb begin
      ref_we_c         = 1'b0;
      ref_waddr_c      = idx_ff;
      ref_wdata_c      = '0;
      stack_we_c       = 1'b0;
      stack_waddr_c    = fc_ff[IDX_W-1:0];
      stack_wdata_c    = idx_ff;
      cnt_c            = '0;
      push_c           = 1'b0;
      rsp_status       = rpa_pkg::ST_OK;
      rsp_page_address = '0;
      fc_in            = fc_ff;
      page_sum_c       = 32'(first_page) + 32'(stack_rd_ff);

      if (cmd.walk) begin
         // Clear every count and stack the window pages in ascending order
         ref_we_c      = 1'b1;
         ref_waddr_c   = walk_ff;
         stack_we_c    = (CNT_W'(walk_ff) < window);
         stack_waddr_c = walk_ff;
         stack_wdata_c = walk_ff;
      end else if (cmd.decode) begin
         if (op_ff == rpa_pkg::OP_INIT) fc_in = window;
      end else if (cmd.complete) begin
         case (op_ff)
            rpa_pkg::OP_INIT: ;
            rpa_pkg::OP_ALLOC: begin
               if (empty_ff) begin
                  rsp_status = rpa_pkg::ST_OOM;
               end else begin
                  ref_we_c         = 1'b1;
                  ref_waddr_c      = stack_rd_ff;
                  ref_wdata_c      = COUNT_ONE;
                  cnt_c            = COUNT_ONE;
                  rsp_page_address = page_sum_c << PS;
                  fc_in            = fc_ff - CNT_W'(1);
               end
            end
            rpa_pkg::OP_ADDREF: begin
               if (!ok_ff) begin
                  rsp_status = rpa_pkg::ST_BADADDR;
               end else begin
                  cnt_c = ref_rd_ff;
                  if (ref_rd_ff == '0) begin
                     rsp_status = rpa_pkg::ST_BADADDR;
                  end else if (ref_rd_ff == COUNT_MAX) begin
                     rsp_status = rpa_pkg::ST_SATURATED;
                  end else begin
                     cnt_c       = ref_rd_ff + COUNT_ONE;
                     ref_we_c    = 1'b1;
                     ref_wdata_c = cnt_c;
                  end
               end
            end
            rpa_pkg::OP_FREE: begin
               if (!ok_ff) begin
                  rsp_status = rpa_pkg::ST_BADADDR;
               end else if (ref_rd_ff == '0) begin
                  rsp_status = rpa_pkg::ST_DOUBLEFREE;
               end else begin
                  cnt_c       = ref_rd_ff - COUNT_ONE;
                  ref_we_c    = 1'b1;
                  ref_wdata_c = cnt_c;
                  if (cnt_c == '0 && fc_ff < CNT_W'(NUM_PAGES)) begin
                     push_c     = 1'b1;
                     stack_we_c = 1'b1;
                     fc_in      = fc_ff + CNT_W'(1);
                  end
               end
            end
            default: ;
         endcase
      end
      cnt_ext_c = {8'b0, cnt_c};
   end

   // Free page count
   always_ff @(posedge clock) begin
      if (reset) begin
         fc_ff <= '0;
      end else begin
         fc_ff <= fc_in;
      end
   end

   // Free stack memory
   always_ff @(posedge clock) begin
      if (stack_we_c) stack_mem[stack_waddr_c] <= stack_wdata_c;
      if (cmd.decode) stack_rd_ff <= stack_mem[stack_raddr_c];
   end

   // Reference count memory
   always_ff @(posedge clock) begin
      if (ref_we_c) ref_mem[ref_waddr_c] <= ref_wdata_c;
      if (cmd.decode) ref_rd_ff <= ref_mem[lk_idx_c];
   end

   assign rsp_valid            = cmd.complete;
   assign rsp_ref_count        = cnt_ext_c[7:0];
   assign rsp_returned_to_pool = push_c;

`ifndef SYNTHESIS
   a_fc_bound: assert property (@(posedge clock) disable iff (reset)
      fc_ff <= CNT_W'(NUM_PAGES))
      else $error("free page count above pool size");
   a_push_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_returned_to_pool) |-> (rsp_status == rpa_pkg::ST_OK && rsp_ref_count == '0))
      else $error("page returned with error status or live count");
   a_fail_no_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != rpa_pkg::ST_OK) |-> (rsp_page_address == '0 && !ref_we_c))
      else $error("failed transaction changed a count or gave an address");
`endif

endmodule

@@ src/refcounted_page_allocator_unit.sv @@
// Top level of the reference-counted page allocator.
//
// Usage:
//   Configuration (APB-style, always ready): mem_first_page at byte address 0,
//   mem_page_count at address 4. Write only while the block is idle.
//   Command channel: a transaction is taken when start is high and busy is low.
//   req_opcode selects allocate, free, add reference or initialize; req_address
//   is the page byte address for free and add reference.
//   Result channel: rsp_valid marks one result per transaction for exactly one
//   cycle; the receiver cannot stall, so it must take every result.
// Sequencing:
//   Allocate, free and add reference: the decode state reads a count or
//   stack entry, then the complete state gives the result and any write-back.
//   busy is low in the result cycle, so the next transaction can be taken there.
//   Initialize: a walk clears one count per cycle, stacking the window pages.
// Reset: the free stack is empty and the window registers take their defaults;
//   issue initialize before any other command.
module refcounted_page_allocator_unit #(
   parameter int NUM_PAGES     = 32768,
   parameter int PAGE_BYTES    = 4096,
   parameter int REFCOUNT_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_address,
   output logic        rsp_valid,
   output logic [31:0] rsp_page_address,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_ref_count,
   output logic        rsp_returned_to_pool
);

   localparam int CNT_W = $clog2(NUM_PAGES + 1);

   logic [rpa_pkg::FIRST_PAGE_W-1:0] first_page;
   logic [CNT_W-1:0]                 window;
   rpa_pkg::ctrl_cmd_type            cmd;
   rpa_pkg::dp_status_type           dp_status;

   rpa_csr #(
      .NUM_PAGES (NUM_PAGES),
      .PAGE_BYTES(PAGE_BYTES),
      .CNT_W     (CNT_W)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .first_page(first_page),
      .window    (window)
   );

   rpa_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .dp_status(dp_status),
      .cmd      (cmd)
   );

   rpa_dp #(
      .NUM_PAGES    (NUM_PAGES),
      .PAGE_BYTES   (PAGE_BYTES),
      .REFCOUNT_BITS(REFCOUNT_BITS),
      .CNT_W        (CNT_W)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .dp_status           (dp_status),
      .req_opcode          (req_opcode),
      .req_address         (req_address),
      .first_page          (first_page),
      .window              (window),
      .rsp_valid           (rsp_valid),
      .rsp_page_address    (rsp_page_address),
      .rsp_status          (rsp_status),
      .rsp_ref_count       (rsp_ref_count),
      .rsp_returned_to_pool(rsp_returned_to_pool)
   );

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the reference-counted page allocator.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_PAGES     = 32768;
   localparam int PAGE_BYTES    = 4096;
   localparam int REFCOUNT_BITS = 8;
   localparam int COUNT_MAX     = (1 << REFCOUNT_BITS) - 1;
   localparam longint unsigned ADDRESSABLE_PAGES = 64'h1_0000_0000 / PAGE_BYTES;
   // an initialize walks every page with nothing moving on either channel
   localparam int WATCHDOG_LIMIT = 4 * (NUM_PAGES + 2 + 64);
   localparam logic [2:0] FIRST_PAGE_ADDR = {rpa_pkg::CSR_IDX_FIRST_PAGE, 2'b00};
   localparam logic [2:0] PAGE_COUNT_ADDR = {rpa_pkg::CSR_IDX_PAGE_COUNT, 2'b00};

   typedef struct packed {
      logic [31:0] page_address;
      logic [2:0]  status;
      logic [7:0]  ref_count;
      logic        returned;
   } page_result_type;

   // Mirror of the allocator: window, free stack, counts, and the results still owed
   class page_pool_scoreboard;
      bit [19:0]       first_page;
      bit [15:0]       page_count;
      bit [14:0]       free_stack [NUM_PAGES];
      int unsigned     stacked;
      bit [7:0]        ref_counts [NUM_PAGES];
      int unsigned     live_pages [$];
      bit [31:0]       last_alloc_address;
      page_result_type pending_results [$];
      int              failures;

      function new();
         first_page = '0;
         page_count = rpa_pkg::PAGE_COUNT_RESET;
      endfunction

      function int unsigned window_pages();
         longint unsigned n;
         n = (page_count > NUM_PAGES) ? NUM_PAGES : page_count;
         if (n > ADDRESSABLE_PAGES - first_page)
            n = ADDRESSABLE_PAGES - first_page;
         return 32'(n);
      endfunction

      function bit [31:0] address_of(input int unsigned idx);
         longint unsigned a;
         a = first_page;
         a = (a + idx) * PAGE_BYTES;
         return a[31:0];
      endfunction

      // map a byte address to a window slot; misaligned or outside gives 0
      function bit find_slot(input bit [31:0] addr, output int unsigned idx);
         bit [31:0] page;
         idx = 0;
         page = addr / PAGE_BYTES;
         if (addr % PAGE_BYTES != 0 || page < first_page ||
             page - first_page >= window_pages())
            return 0;
         idx = page - first_page;
         return 1;
      endfunction

      function int unsigned count_at(input bit [31:0] addr);
         int unsigned idx;
         if (!find_slot(addr, idx))
            return 0;
         return ref_counts[idx];
      endfunction

      function void apply_register(input logic [2:0] addr, input bit [31:0] value);
         if (addr[2] == rpa_pkg::CSR_IDX_FIRST_PAGE)
            first_page = value[19:0];
         else
            page_count = value[15:0];
      endfunction

      // advance the mirror by one accepted command and queue its result
      function void note_command(input logic [1:0] op, input logic [31:0] addr);
         page_result_type r;
         int unsigned     idx, n;
         int              where [$];
         r = '0;
         case (op)
            rpa_pkg::OP_INIT: begin
               foreach (ref_counts[i])
                  ref_counts[i] = '0;
               n = window_pages();
               for (int i = 0; i < n; i++)
                  free_stack[i] = 15'(i);
               stacked = n;
               live_pages.delete();
            end
            rpa_pkg::OP_ALLOC: begin
               if (stacked == 0 || stacked > NUM_PAGES) begin
                  r.status = rpa_pkg::ST_OOM;
                  last_alloc_address = '0;
               end else begin
                  stacked--;
                  idx = free_stack[stacked];
                  ref_counts[idx] = 8'd1;
                  r.page_address = address_of(idx);
                  r.ref_count = 8'd1;
                  live_pages.push_back(idx);
                  last_alloc_address = r.page_address;
               end
            end
            default: begin
               if (!find_slot(addr, idx)) begin
                  r.status = rpa_pkg::ST_BADADDR;
               end else if (op == rpa_pkg::OP_ADDREF) begin
                  if (ref_counts[idx] == 0) begin
                     r.status = rpa_pkg::ST_BADADDR;
                  end else if (ref_counts[idx] >= COUNT_MAX) begin
                     r.status = rpa_pkg::ST_SATURATED;
                     r.ref_count = ref_counts[idx];
                  end else begin
                     ref_counts[idx]++;
                     r.ref_count = ref_counts[idx];
                  end
               end else if (ref_counts[idx] == 0) begin
                  r.status = rpa_pkg::ST_DOUBLEFREE;
               end else begin
                  ref_counts[idx]--;
                  r.ref_count = ref_counts[idx];
                  if (ref_counts[idx] == 0) begin
                     if (stacked < NUM_PAGES) begin
                        free_stack[stacked] = 15'(idx);
                        stacked++;
                        r.returned = 1'b1;
                     end
                     where = live_pages.find_first_index(p) with (p == idx);
                     if (where.size() != 0)
                        live_pages.delete(where[0]);
                  end
               end
            end
         endcase
         pending_results.push_back(r);
      endfunction

      function void compare_field(input string name, input logic [31:0] want,
                                  input logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            failures++;
         end
      endfunction

      function void check_result(input page_result_type got);
         page_result_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: result with none outstanding: expected none, actual %h",
                     $time, got);
            failures++;
            return;
         end
         want = pending_results.pop_front();
         compare_field("page_address", want.page_address, got.page_address);
         compare_field("status", 32'(want.status), 32'(got.status));
         compare_field("ref_count", 32'(want.ref_count), 32'(got.ref_count));
         compare_field("returned_to_pool", 32'(want.returned), 32'(got.returned));
      endfunction
   endclass

   logic        clock, reset;
   logic        psel, penable, pwrite, pready;
   logic [2:0]  paddr;
   logic [31:0] pwdata, prdata;
   logic        start, busy;
   logic [1:0]  req_opcode;
   logic [31:0] req_address;
   logic        rsp_valid, rsp_returned_to_pool;
   logic [31:0] rsp_page_address;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_ref_count;

   page_pool_scoreboard ledger;
   int                  idle_pct;
   int                  items_sent;
   int                  quiet_cycles;

   refcounted_page_allocator_unit #(
      .NUM_PAGES     (NUM_PAGES),
      .PAGE_BYTES    (PAGE_BYTES),
      .REFCOUNT_BITS (REFCOUNT_BITS)
   ) dut (
      .clock                (clock),
      .reset                (reset),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .pready               (pready),
      .start                (start),
      .busy                 (busy),
      .req_opcode           (req_opcode),
      .req_address          (req_address),
      .rsp_valid            (rsp_valid),
      .rsp_page_address     (rsp_page_address),
      .rsp_status           (rsp_status),
      .rsp_ref_count        (rsp_ref_count),
      .rsp_returned_to_pool (rsp_returned_to_pool)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Check every result strobe; end the run if both channels go quiet too long
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid === 1'b1)
            ledger.check_result(page_result_type'{rsp_page_address, rsp_status,
                                                  rsp_ref_count, rsp_returned_to_pool});
         if ((start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired with %0d results outstanding",
                     $time, ledger.pending_results.size());
            $display("[refcounted_page_allocator_unit] ERROR");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Present one command, sometimes after a random gap, and hold it until taken
   task automatic issue_command(input logic [1:0] op, input logic [31:0] addr);
      int gap;
      if ($urandom_range(99) < idle_pct) begin
         gap = $urandom_range(4, 1);
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start <= 1'b1;
      req_opcode <= op;
      req_address <= addr;
      do @(posedge clock); while (busy !== 1'b0);
      ledger.note_command(op, addr);
      items_sent++;
   endtask

   // Drop start and hold off until every outstanding result has arrived
   task automatic wait_results_done();
      @(negedge clock);
      start <= 1'b0;
      while (ledger.pending_results.size() != 0)
         @(negedge clock);
   endtask

   // Write one register, then read it back
   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      ledger.apply_register(addr, value);
      @(negedge clock);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (prdata !== value) begin
         $display("%0t: register %0d readback mismatch: expected %0h, actual %0h",
                  $time, addr, value, prdata);
         ledger.failures++;
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // Move the window while idle, optionally rebuilding the pool
   task automatic set_window(input bit [19:0] first, input bit [15:0] count,
                             input bit reinit);
      wait_results_done();
      repeat (4) @(negedge clock);
      csr_write(FIRST_PAGE_ADDR, 32'(first));
      csr_write(PAGE_COUNT_ADDR, 32'(count));
      if (reinit)
         issue_command(rpa_pkg::OP_INIT, $urandom());
   endtask

   function automatic logic [31:0] window_address();
      int unsigned n;
      n = ledger.window_pages();
      return ledger.address_of((n == 0) ? 0 : $urandom_range(n - 1));
   endfunction

   function automatic logic [31:0] live_address();
      if (ledger.live_pages.size() == 0)
         return window_address();
      return ledger.address_of(
         ledger.live_pages[$urandom_range(ledger.live_pages.size() - 1)]);
   endfunction

   // Addresses that mostly miss: random, misaligned, just past or below the window
   function automatic logic [31:0] stray_address();
      case ($urandom_range(4))
         0: return $urandom();
         1: return window_address() | 32'($urandom_range(PAGE_BYTES - 1, 1));
         2: return ledger.address_of(ledger.window_pages());
         3: return ledger.address_of(32'hFFFF_FFFF);
         default: return window_address();
      endcase
   endfunction

   // Mostly well-formed page lifetimes, with noise and broken sequences mixed in
   task automatic run_random_phase(input int quota, input bit pump);
      int          first_item, pump_at, kind, reps;
      logic [31:0] addr;
      first_item = items_sent;
      pump_at = $urandom_range(quota / 2, quota / 4);
      while (items_sent - first_item < quota) begin
         kind = $urandom_range(99);
         if (pump && items_sent - first_item >= pump_at) begin
            // hammer one held page past its count limit
            if (ledger.live_pages.size() == 0)
               issue_command(rpa_pkg::OP_ALLOC, $urandom());
            addr = live_address();
            repeat ($urandom_range(270, 255)) issue_command(rpa_pkg::OP_ADDREF, addr);
            pump = 1'b0;
         end else if (kind < 25) begin
            repeat ($urandom_range(4, 1)) issue_command(rpa_pkg::OP_ALLOC, $urandom());
         end else if (kind < 45) begin
            addr = live_address();
            repeat ($urandom_range(3, 1)) issue_command(rpa_pkg::OP_ADDREF, addr);
         end else if (kind < 68) begin
            addr = live_address();
            repeat ($urandom_range(3, 1)) issue_command(rpa_pkg::OP_FREE, addr);
         end else if (kind < 80) begin
            // whole lifetime of one page, sometimes ending in a double free
            issue_command(rpa_pkg::OP_ALLOC, $urandom());
            addr = ledger.last_alloc_address;
            reps = $urandom_range(3);
            repeat (reps) issue_command(rpa_pkg::OP_ADDREF, addr);
            repeat (reps + 1 + ($urandom_range(2) == 0))
               issue_command(rpa_pkg::OP_FREE, addr);
         end else if (kind < 95) begin
            issue_command(2'($urandom_range(2)), stray_address());
         end else if (kind < 98) begin
            // walk one held page all the way back to the pool
            addr = live_address();
            reps = 0;
            while (ledger.count_at(addr) != 0 && reps < 300) begin
               issue_command(rpa_pkg::OP_FREE, addr);
               reps++;
            end
         end else begin
            wait_results_done();
         end
      end
   endtask

   initial begin
      ledger = new();
      reset = 1'b1;
      start = 1'b0;
      req_opcode = rpa_pkg::OP_ALLOC;
      req_address = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      idle_pct = 0;
      items_sent = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // before the first initialize: empty stack, addresses that never reach a count
      issue_command(rpa_pkg::OP_ALLOC, 32'hFFFF_FFFF);
      issue_command(rpa_pkg::OP_FREE, 32'h0000_0001);
      issue_command(rpa_pkg::OP_ADDREF, 32'hFFFF_F000);
      issue_command(rpa_pkg::OP_FREE, 32'h0800_0000);

      // full default window: the highest page comes out first
      issue_command(rpa_pkg::OP_INIT, 32'h0000_0000);
      issue_command(rpa_pkg::OP_ALLOC, 32'h0000_0000);
      issue_command(rpa_pkg::OP_ALLOC, 32'h0000_0000);
      issue_command(rpa_pkg::OP_ADDREF, 32'h07FF_F000);
      issue_command(rpa_pkg::OP_FREE, 32'h07FF_F000);
      issue_command(rpa_pkg::OP_FREE, 32'h07FF_F000);

      // double free, add reference to a pooled page, misaligned and out of range
      issue_command(rpa_pkg::OP_FREE, 32'h07FF_F000);
      issue_command(rpa_pkg::OP_ADDREF, 32'h07FF_F000);
      issue_command(rpa_pkg::OP_FREE, 32'h0000_0000);
      issue_command(rpa_pkg::OP_ADDREF, 32'h07FF_E001);
      issue_command(rpa_pkg::OP_FREE, 32'hFFFF_FFFF);
      issue_command(rpa_pkg::OP_ALLOC, 32'h0000_0000);

      // one-page window at the top of the address space, count register at max
      set_window(20'hF_FFFF, 16'hFFFF, 1'b1);
      issue_command(rpa_pkg::OP_ALLOC, 32'h0000_0000);
      issue_command(rpa_pkg::OP_ALLOC, 32'h0000_0000);
      issue_command(rpa_pkg::OP_FREE, 32'hFFFF_F000);
      issue_command(rpa_pkg::OP_FREE, 32'hFFFF_F000);

      // empty window
      set_window(20'h0_0000, 16'h0000, 1'b1);
      issue_command(rpa_pkg::OP_ALLOC, 32'h0000_0000);
      issue_command(rpa_pkg::OP_FREE, 32'h0000_0000);

      // small window, back-to-back commands
      idle_pct = 0;
      set_window(20'($urandom()), 16'($urandom_range(48, 1)), 1'b1);
      run_random_phase(280, 1'b1);

      // random window, sparse commands
      idle_pct = 65;
      set_window(20'($urandom()), 16'($urandom()), 1'b1);
      run_random_phase(280, 1'b0);

      // shift the window without rebuilding: held pages keep their offsets
      idle_pct = 17;
      set_window(ledger.first_page + 20'($urandom_range(3, 1)), ledger.page_count, 1'b0);
      run_random_phase(280, 1'b0);

      // window clipped at the top of the address space
      idle_pct = 65;
      set_window(20'hF_FFFF - 20'($urandom_range(40)), 16'd32768, 1'b1);
      run_random_phase(280, 1'b1);

      // two pages from address zero: constant out-of-memory pressure
      idle_pct = 0;
      set_window(20'h0_0000, 16'd2, 1'b1);
      run_random_phase(280, 1'b0);

      wait_results_done();
      repeat (8) @(posedge clock);
      if (ledger.failures == 0)
         $display("[refcounted_page_allocator_unit] OK");
      else
         $display("[refcounted_page_allocator_unit] ERROR");
      $finish;
   end
endmodule
